// File: design/tagged_chunk_slot_pool_top_macros.svh
// assertion macros shared by the pool design
`ifndef TAGGED_CHUNK_SLOT_POOL_TOP_MACROS_SVH
`define TAGGED_CHUNK_SLOT_POOL_TOP_MACROS_SVH

// antecedent holds, consequent holds in the same cycle
`define TCSP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tcsp assertion failed");

// antecedent holds, consequent holds in the next cycle
`define TCSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tcsp assertion failed");

`endif

// File: design/tcsp_pkg.sv
package tcsp_pkg;

    localparam logic [1:0] OP_ENQUEUE = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    localparam logic CFG_CHUNK_BYTES  = 1'b0;
    localparam logic CFG_SLOTS_IN_USE = 1'b1;

    localparam logic [11:0] CHUNK_BYTES_RESET = 12'd256;
    localparam logic [4:0]  SLOTS_RESET       = 5'd16;
    localparam logic [15:0] SEQ_MAX           = 16'hFFFF;
    localparam logic [11:0] OFFSET_MAX        = 12'hFFF;

    typedef enum logic [3:0] {
        ST_ACCEPTED    = 4'd0,
        ST_PUBLISHED   = 4'd1,
        ST_TOO_BIG     = 4'd2,
        ST_NO_SLOT     = 4'd3,
        ST_READ        = 4'd4,
        ST_BAD_ID      = 4'd5,
        ST_SMALL_BUF   = 4'd6,
        ST_RELEASED    = 4'd7,
        ST_NONE        = 4'd8,
        ST_BAD_SETTING = 4'd9
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_RCHK, S_RMEM, S_RDAT,
        S_EADD, S_EWR, S_SCAN, S_ZADD, S_ZERO, S_OUT
    } t_state;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] event_code;
        logic [11:0] chunk_length;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [31:0] read_tag;
        logic [15:0] buffer_size;
        logic [11:0] byte_offset;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [31:0] tag_out;
        logic [31:0] event_out;
        logic        publish;
        logic [7:0]  byte_out;
    } t_out_item;

    // control of the shared address unit
    typedef struct packed {
        logic mul;
        logic add;
        logic inc;
    } t_au_ctrl;

    typedef struct packed {
        logic [15:0] seq;
        logic [11:0] len;
    } t_meta;

endpackage

// File: design/tcsp_ram.sv
module tcsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/tcsp_addr_unit.sv
module tcsp_addr_unit #(
    parameter int MEMORY_BYTES = 4096,
    parameter int SLOT_COUNT   = 16
) (
    input  logic                            i_clk,
    input  tcsp_pkg::t_au_ctrl              i_ctrl,
    input  logic [$clog2(SLOT_COUNT)-1:0]   i_idx,
    input  logic [11:0]                     i_cb,
    input  logic [11:0]                     i_off,
    output logic [$clog2(MEMORY_BYTES)-1:0] o_addr,
    output logic                            o_in_range
);
    import tcsp_pkg::*;

    localparam int PW = $clog2(SLOT_COUNT);
    localparam int AW = $clog2(MEMORY_BYTES);
    localparam int WA = (PW + 13 > AW) ? PW + 13 : AW;

    logic [PW+11:0] r_base;
    logic [WA-1:0]  r_addr;

    // slot base is registered before the offset add
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul) begin
            r_base <= (PW+12)'(i_idx) * (PW+12)'(i_cb);
        end
        if (i_ctrl.add) begin
            r_addr <= WA'(r_base) + WA'(i_off);
        end else if (i_ctrl.inc) begin
            r_addr <= r_addr + WA'(1);
        end
    end

    assign o_addr     = r_addr[AW-1:0];
    assign o_in_range = 32'(r_addr) < 32'(MEMORY_BYTES);
endmodule

// File: design/tagged_chunk_slot_pool_top.sv
// enqueue word: decode with slot-base multiply, offset add, byte write; a chunk's last
// word adds a free-slot scan; read: check, byte read; release: byte zeroing pass
// throughput: one word at a time, set by the shared slot-address multiply/add unit
// reset: synchronous active low; then a clearing pass over every byte of the memory
// a write of slots_in_use restarts that clearing pass; no word is taken meanwhile
`include "tagged_chunk_slot_pool_top_macros.svh"

module tagged_chunk_slot_pool_top #(
    parameter int MEMORY_BYTES = 4096,
    parameter int SLOT_COUNT   = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tcsp_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tcsp_pkg::t_out_item o_out,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [11:0]         i_cfg_wdata
);
    import tcsp_pkg::*;

    localparam int PW = $clog2(SLOT_COUNT);
    localparam int AW = $clog2(MEMORY_BYTES);

    function automatic logic [PW:0] f_active(input logic [4:0] s);
        return (32'(s) < 32'(SLOT_COUNT)) ? (PW+1)'(s) : (PW+1)'(SLOT_COUNT);
    endfunction

    function automatic logic [SLOT_COUNT-1:0] f_free_init(input logic [PW:0] a);
        logic [SLOT_COUNT-1:0] v;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            v[i] = 32'(i) < 32'(a);
        end
        return v;
    endfunction

    t_state                r_state, n_state;
    t_in_item              r_in, n_in;
    t_out_item             r_out, n_out;
    logic [11:0]           r_cb, n_cb;
    logic [4:0]            r_slots, n_slots;
    logic [SLOT_COUNT-1:0] r_free, n_free;
    logic [PW-1:0]         r_fp, n_fp;
    logic [15:0]           r_seq, n_seq;
    logic                  r_deq_v, n_deq_v;
    logic [PW-1:0]         r_deq, n_deq;
    logic [11:0]           r_wo, n_wo;
    logic                  r_busy, n_busy;
    logic [11:0]           r_cur_len, n_cur_len;
    logic [AW-1:0]         r_clr, n_clr;
    logic [11:0]           r_cnt, n_cnt;
    logic [PW:0]           r_scan_k, n_scan_k;
    logic [PW-1:0]         r_scan_s, n_scan_s;
    logic                  r_rd_zero, n_rd_zero;

    logic [PW:0]   act;
    logic [16:0]   cfg_prod;
    logic          good;
    t_au_ctrl      au_ctrl;
    logic [PW-1:0] au_idx;
    logic [11:0]   au_off;
    logic [AW-1:0] au_addr;
    logic          au_in_range;
    logic          bs_we;
    logic [AW-1:0] bs_waddr;
    logic [7:0]    bs_wdata;
    logic [7:0]    bs_rdata;
    logic          mt_we;
    t_meta         mt_wdata;
    t_meta         mt_rdata;
    logic [PW-1:0] rd_idx;
    logic [PW-1:0] scan_nx;
    logic          in_fire;

    assign act      = f_active(r_slots);
    assign cfg_prod = 17'(r_cb) * 17'(r_slots);
    assign good     = (r_cb != 12'd0) && (r_slots != 5'd0)
                      && (32'(r_slots) <= 32'(SLOT_COUNT))
                      && (32'(cfg_prod) < 32'(MEMORY_BYTES));
    assign rd_idx   = r_in.read_tag[PW-1:0];
    assign scan_nx  = (32'(r_scan_s) + 32'd1 >= 32'(act)) ? '0 : r_scan_s + PW'(1);
    assign in_fire  = i_in_valid && !o_in_stall;

    tcsp_addr_unit #(
        .MEMORY_BYTES(MEMORY_BYTES),
        .SLOT_COUNT  (SLOT_COUNT)
    ) u_au (
        .i_clk     (i_clk),
        .i_ctrl    (au_ctrl),
        .i_idx     (au_idx),
        .i_cb      (r_cb),
        .i_off     (au_off),
        .o_addr    (au_addr),
        .o_in_range(au_in_range)
    );

    tcsp_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_bytes (
        .i_clk  (i_clk),
        .i_we   (bs_we),
        .i_waddr(bs_waddr),
        .i_wdata(bs_wdata),
        .i_raddr(au_addr),
        .o_rdata(bs_rdata)
    );

    tcsp_ram #(.WIDTH($bits(t_meta)), .DEPTH(SLOT_COUNT)) u_meta (
        .i_clk  (i_clk),
        .i_we   (mt_we),
        .i_waddr(r_fp),
        .i_wdata(mt_wdata),
        .i_raddr(rd_idx),
        .o_rdata(mt_rdata)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out       = r_out;

    always_comb begin
        n_state   = r_state;
        n_in      = r_in;
        n_out     = r_out;
        n_cb      = r_cb;
        n_slots   = r_slots;
        n_free    = r_free;
        n_fp      = r_fp;
        n_seq     = r_seq;
        n_deq_v   = r_deq_v;
        n_deq     = r_deq;
        n_wo      = r_wo;
        n_busy    = r_busy;
        n_cur_len = r_cur_len;
        n_clr     = r_clr;
        n_cnt     = r_cnt;
        n_scan_k  = r_scan_k;
        n_scan_s  = r_scan_s;
        n_rd_zero = r_rd_zero;
        au_ctrl   = '0;
        au_idx    = r_fp;
        au_off    = 12'd0;
        bs_we     = 1'b0;
        bs_waddr  = au_addr;
        bs_wdata  = 8'd0;
        mt_we     = 1'b0;
        mt_wdata  = '{seq: r_seq, len: r_cur_len};

        unique case (r_state)
            S_CLEAR: begin
                bs_we    = 1'b1;
                bs_waddr = r_clr;
                if (r_clr == AW'(MEMORY_BYTES - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_out   = '0;
                n_state = S_OUT;
                unique case (r_in.opcode)
                    OP_ENQUEUE: begin
                        au_idx = r_fp;
                        if (!good || (32'(r_fp) >= 32'(act))) begin
                            n_busy       = 1'b0;
                            n_out.status = ST_BAD_SETTING;
                        end else if (!r_busy) begin
                            if (r_in.chunk_length >= r_cb) begin
                                n_out.status = ST_TOO_BIG;
                            end else if (!r_free[r_fp]) begin
                                n_out.status = ST_NO_SLOT;
                            end else begin
                                n_cur_len   = r_in.chunk_length;
                                n_wo        = 12'd0;
                                n_busy      = 1'b1;
                                au_ctrl.mul = 1'b1;
                                n_state     = S_EADD;
                            end
                        end else begin
                            au_ctrl.mul = 1'b1;
                            n_state     = S_EADD;
                        end
                    end
                    OP_READ: begin
                        au_idx      = rd_idx;
                        au_ctrl.mul = 1'b1;
                        n_state     = S_RCHK;
                    end
                    OP_RELEASE: begin
                        au_idx = r_deq;
                        if (!r_deq_v) begin
                            n_out.status = ST_NONE;
                        end else begin
                            n_free[r_deq] = 1'b1;
                            if (!r_free[r_fp]) begin
                                n_fp = r_deq;
                            end
                            n_deq_v      = 1'b0;
                            n_deq        = '0;
                            n_out.status = ST_RELEASED;
                            au_ctrl.mul  = 1'b1;
                            n_state      = S_ZADD;
                        end
                    end
                    default: begin
                        n_out.status = ST_NONE;
                    end
                endcase
            end
            S_EADD: begin
                au_off      = r_wo;
                au_ctrl.add = 1'b1;
                n_state     = S_EWR;
            end
            S_EWR: begin
                bs_wdata = r_in.data_byte;
                bs_we    = (r_wo < r_cur_len) && au_in_range;
                if (r_wo != OFFSET_MAX) begin
                    n_wo = r_wo + 12'd1;
                end
                if (!r_in.last_byte) begin
                    n_out.status = ST_ACCEPTED;
                    n_state      = S_OUT;
                end else begin
                    mt_we           = 1'b1;
                    n_free[r_fp]    = 1'b0;
                    n_out.status    = ST_PUBLISHED;
                    n_out.tag_out   = {r_seq, 16'(r_fp)};
                    n_out.event_out = r_in.event_code;
                    n_out.publish   = 1'b1;
                    n_seq           = (r_seq == SEQ_MAX) ? 16'd1 : r_seq + 16'd1;
                    n_busy          = 1'b0;
                    n_wo            = 12'd0;
                    n_scan_s        = r_fp;
                    n_scan_k        = '0;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                // cyclic search for the next free slot
                if (r_free[scan_nx]) begin
                    n_fp    = scan_nx;
                    n_state = S_OUT;
                end else begin
                    n_scan_s = scan_nx;
                    n_scan_k = r_scan_k + (PW+1)'(1);
                    if (32'(r_scan_k) + 32'd1 >= 32'(act)) begin
                        n_state = S_OUT;
                    end
                end
            end
            S_RCHK: begin
                n_state = S_OUT;
                if ((32'(r_in.read_tag[15:0]) >= 32'(act)) || r_free[rd_idx]
                        || (mt_rdata.seq != r_in.read_tag[31:16])) begin
                    n_out.status = ST_BAD_ID;
                end else if (r_in.buffer_size < 16'(mt_rdata.len)) begin
                    n_out.status = ST_SMALL_BUF;
                end else begin
                    au_off      = r_in.byte_offset;
                    au_ctrl.add = 1'b1;
                    n_rd_zero   = !(r_in.byte_offset < mt_rdata.len);
                    n_state     = S_RMEM;
                end
            end
            S_RMEM: begin
                if (!au_in_range) begin
                    n_rd_zero = 1'b1;
                end
                n_state = S_RDAT;
            end
            S_RDAT: begin
                n_out.status   = ST_READ;
                n_out.byte_out = r_rd_zero ? 8'd0 : bs_rdata;
                n_deq_v        = 1'b1;
                n_deq          = rd_idx;
                n_state        = S_OUT;
            end
            S_ZADD: begin
                au_off      = 12'd0;
                au_ctrl.add = 1'b1;
                n_cnt       = 12'd0;
                n_state     = S_ZERO;
            end
            S_ZERO: begin
                if ((r_cnt == r_cb) || !au_in_range) begin
                    n_state = S_OUT;
                end else begin
                    bs_we       = 1'b1;
                    au_ctrl.inc = 1'b1;
                    n_cnt       = r_cnt + 12'd1;
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CHUNK_BYTES: begin
                    n_cb = i_cfg_wdata;
                end
                CFG_SLOTS_IN_USE: begin
                    n_slots = i_cfg_wdata[4:0];
                    n_free  = f_free_init(f_active(i_cfg_wdata[4:0]));
                    n_fp    = '0;
                    n_deq_v = 1'b0;
                    n_deq   = '0;
                    n_wo    = 12'd0;
                    n_busy  = 1'b0;
                    n_clr   = '0;
                    n_state = S_CLEAR;
                end
                default: begin
                    n_cb = r_cb;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cb    <= CHUNK_BYTES_RESET;
            r_slots <= SLOTS_RESET;
            r_free  <= f_free_init(f_active(SLOTS_RESET));
            r_fp    <= '0;
            r_seq   <= 16'd1;
            r_deq_v <= 1'b0;
            r_deq   <= '0;
            r_wo    <= 12'd0;
            r_busy  <= 1'b0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_cb    <= n_cb;
            r_slots <= n_slots;
            r_free  <= n_free;
            r_fp    <= n_fp;
            r_seq   <= n_seq;
            r_deq_v <= n_deq_v;
            r_deq   <= n_deq;
            r_wo    <= n_wo;
            r_busy  <= n_busy;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in      <= n_in;
        r_out     <= n_out;
        r_cur_len <= n_cur_len;
        r_cnt     <= n_cnt;
        r_scan_k  <= n_scan_k;
        r_scan_s  <= n_scan_s;
        r_rd_zero <= n_rd_zero;
    end

    `TCSP_ASSERT_SAME(a_out_blocks_in, i_clk, i_rst_n, o_out_valid, o_in_stall)
    `TCSP_ASSERT_SAME(a_deq_not_free, i_clk, i_rst_n, r_deq_v, !r_free[r_deq])
    `TCSP_ASSERT_NEXT(a_accept_decodes, i_clk, i_rst_n, in_fire && !i_cfg_we, r_state == S_DECODE)
    `TCSP_ASSERT_SAME(a_publish_tag, i_clk, i_rst_n, o_out_valid && o_out.publish, (o_out.status == ST_PUBLISHED) && (o_out.tag_out[31:16] != 16'd0))
endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import tcsp_pkg::*;

    localparam int MEM_BYTES  = 4096;
    localparam int NUM_SLOTS  = 16;
    localparam int IDLE_LIMIT = 40000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in_item    in_word = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_item   out_word;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [11:0] cfg_wdata = '0;

    tagged_chunk_slot_pool_top i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in(in_word),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out(out_word),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_wdata(cfg_wdata)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow of the pool
    logic [11:0] m_chunk;
    logic [4:0]  m_slots;
    logic [7:0]  m_mem [MEM_BYTES];
    logic [31:0] m_tag [NUM_SLOTS];
    logic [11:0] m_len [NUM_SLOTS];
    logic        m_free [NUM_SLOTS];
    int          m_fp;
    logic [15:0] m_seq;
    logic        m_deq_ok;
    int          m_deq;
    logic [11:0] m_woff;
    logic        m_busy;

    t_out_item   pending_results[$];
    int          errors = 0;
    int          mismatches = 0;
    int          n_words = 0;
    int          n_results = 0;
    int          n_pub = 0;
    int          n_reads = 0;
    int          idle_cycles = 0;
    int          send_idle = 13;
    int          recv_idle = 73;

    function automatic int live_slots();
        return (m_slots < NUM_SLOTS) ? int'(m_slots) : NUM_SLOTS;
    endfunction

    function automatic bit setting_ok();
        if (m_chunk == 0 || m_slots == 0 || m_slots > NUM_SLOTS) return 1'b0;
        return int'(m_chunk) * int'(m_slots) < MEM_BYTES;
    endfunction

    function automatic void wipe_pool();
        int n;
        n = live_slots();
        for (int i = 0; i < MEM_BYTES; i++) m_mem[i] = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            m_tag[i] = '0;
            m_len[i] = '0;
            m_free[i] = (i < n);
        end
        m_fp = 0;
        m_deq_ok = 1'b0;
        m_deq = 0;
        m_woff = '0;
        m_busy = 1'b0;
    endfunction

    function automatic t_out_item pool_step(t_in_item w);
        t_out_item r;
        int n, a, s;
        r = '0;
        n = live_slots();
        case (w.opcode)
            OP_ENQUEUE: begin
                if (!setting_ok() || m_fp >= n) begin
                    m_busy = 1'b0;
                    r.status = ST_BAD_SETTING;
                    return r;
                end
                if (!m_busy) begin
                    if (w.chunk_length >= m_chunk) begin
                        r.status = ST_TOO_BIG;
                        return r;
                    end
                    if (!m_free[m_fp]) begin
                        r.status = ST_NO_SLOT;
                        return r;
                    end
                    m_len[m_fp] = w.chunk_length;
                    m_woff = '0;
                    m_busy = 1'b1;
                end
                if (m_woff < m_len[m_fp]) begin
                    a = m_fp * int'(m_chunk) + int'(m_woff);
                    if (a < MEM_BYTES) m_mem[a] = w.data_byte;
                end
                if (m_woff < OFFSET_MAX) m_woff++;
                if (!w.last_byte) begin
                    r.status = ST_ACCEPTED;
                    return r;
                end
                m_tag[m_fp] = {m_seq, 16'(m_fp)};
                m_free[m_fp] = 1'b0;
                r.status = ST_PUBLISHED;
                r.tag_out = m_tag[m_fp];
                r.event_out = w.event_code;
                r.publish = 1'b1;
                m_seq = (m_seq == SEQ_MAX) ? 16'd1 : m_seq + 16'd1;
                m_busy = 1'b0;
                m_woff = '0;
                s = m_fp;
                for (int k = 0; k < n; k++) begin
                    s = (s + 1 >= n) ? 0 : s + 1;
                    if (m_free[s]) begin
                        m_fp = s;
                        break;
                    end
                end
            end
            OP_READ: begin
                s = int'(w.read_tag[15:0]);
                if (s >= n || m_free[s] || m_tag[s] != w.read_tag) begin
                    r.status = ST_BAD_ID;
                    return r;
                end
                if (w.buffer_size < 16'(m_len[s])) begin
                    r.status = ST_SMALL_BUF;
                    return r;
                end
                r.status = ST_READ;
                if (w.byte_offset < m_len[s]) begin
                    a = s * int'(m_chunk) + int'(w.byte_offset);
                    if (a < MEM_BYTES) r.byte_out = m_mem[a];
                end
                m_deq_ok = 1'b1;
                m_deq = s;
            end
            OP_RELEASE: begin
                if (!m_deq_ok || m_deq >= NUM_SLOTS) begin
                    r.status = ST_NONE;
                    return r;
                end
                s = m_deq;
                m_tag[s] = '0;
                m_len[s] = '0;
                m_free[s] = 1'b1;
                for (int k = 0; k < int'(m_chunk); k++) begin
                    a = s * int'(m_chunk) + k;
                    if (a >= MEM_BYTES) break;
                    m_mem[a] = '0;
                end
                if (m_fp >= NUM_SLOTS || !m_free[m_fp]) m_fp = s;
                m_deq_ok = 1'b0;
                m_deq = 0;
                r.status = ST_RELEASED;
            end
            default: r.status = ST_NONE;
        endcase
        return r;
    endfunction

    // result checking and receiver stalls
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n) begin
            if (in_valid && !in_stall) idle_cycles <= 0;
            else if (out_valid && !out_stall) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (out_valid && !out_stall) begin
                n_results <= n_results + 1;
                if (pending_results.size() == 0) begin
                    errors++;
                    if (mismatches < 10)
                        $display("unexpected word: %p", out_word);
                    mismatches <= mismatches + 1;
                end else begin
                    want = pending_results.pop_front();
                    if (out_word !== want) begin
                        errors++;
                        if (mismatches < 10)
                            $display("mismatch: expected %p got %p", want, out_word);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle);
            if (idle_cycles > IDLE_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    // send one word, optionally with a typed-in expectation
    task automatic send_word(t_in_item w, bit has_want = 0, t_out_item want = '0);
        t_out_item r;
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        r = pool_step(w);
        if (has_want && r !== want) begin
            errors++;
            $display("shadow disagrees with table row: %p vs %p", r, want);
        end
        pending_results.push_back(r);
        n_words++;
        if (r.status == ST_PUBLISHED) n_pub++;
        if (r.status == ST_READ) n_reads++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        // release zeroing pass plus clearing pass margin
        repeat (4200 + 2 * MEM_BYTES) @(posedge clk);
    endtask

    task automatic write_cfg(logic idx, logic [11:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_CHUNK_BYTES) begin
            m_chunk = val;
        end else begin
            m_slots = val[4:0];
            wipe_pool();
        end
    endtask

    function automatic t_in_item enq(logic [11:0] len, logic [7:0] b, logic last,
                                     logic [31:0] ev);
        t_in_item w;
        w = '0;
        w.opcode = OP_ENQUEUE;
        w.chunk_length = len;
        w.data_byte = b;
        w.last_byte = last;
        w.event_code = ev;
        return w;
    endfunction

    function automatic t_in_item rd(logic [31:0] id, logic [15:0] bs, logic [11:0] off);
        t_in_item w;
        w = '0;
        w.opcode = OP_READ;
        w.read_tag = id;
        w.buffer_size = bs;
        w.byte_offset = off;
        return w;
    endfunction

    function automatic t_in_item junk();
        t_in_item w;
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        w = raw[$bits(t_in_item)-1:0];
        return w;
    endfunction

    // random phase: mostly well-formed chunks, reads and releases
    task automatic random_phase(int count);
        int done;
        int len, nb;
        t_in_item w;
        logic [31:0] id;
        done = 0;
        while (done < count) begin
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    len = ($urandom_range(9) == 0) ? $urandom_range(4095)
                                                   : $urandom_range(int'(m_chunk));
                    nb = (len > 6) ? $urandom_range(6, 1) : len + $urandom_range(2);
                    if (nb == 0) nb = 1;
                    for (int i = 0; i < nb; i++) begin
                        w = enq(12'(len), 8'($urandom), (i == nb - 1), $urandom);
                        w.read_tag = $urandom;
                        send_word(w);
                        done++;
                    end
                end
                4, 5, 6: begin
                    id = {16'($urandom_range(65535)), 16'($urandom_range(NUM_SLOTS - 1))};
                    for (int s = 0; s < NUM_SLOTS; s++)
                        if (!m_free[s] && $urandom_range(1)) id = m_tag[s];
                    w = rd(id, ($urandom_range(7) == 0) ? 16'($urandom)
                                                        : 16'(m_chunk + $urandom_range(3)),
                           ($urandom_range(3) == 0) ? 12'($urandom)
                                                    : 12'($urandom_range(7)));
                    send_word(w);
                    done++;
                end
                7, 8: begin
                    w = junk();
                    w.opcode = OP_RELEASE;
                    send_word(w);
                    done++;
                end
                default: begin
                    send_word(junk());
                    done++;
                end
            endcase
        end
    endtask

    initial begin
        t_out_item want;
        t_in_item  plan[$];
        t_out_item plan_want[$];
        bit        plan_has[$];
        m_chunk = CHUNK_BYTES_RESET;
        m_slots = SLOTS_RESET;
        m_seq = 16'd1;
        wipe_pool();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: reset setting is rejected, then small pool
        want = '0;
        want.status = ST_BAD_SETTING;
        plan.push_back(enq(12'd3, 8'hFF, 1'b1, 32'hFFFF_FFFF));
        plan_want.push_back(want); plan_has.push_back(1);
        want.status = ST_NONE;
        plan.push_back(rd(32'h0, 16'h0, 12'h0)); plan_want.push_back('0);
        plan_has.push_back(0);
        plan.push_back(t_in_item'({OP_RELEASE, 113'h0}));
        plan_want.push_back(want); plan_has.push_back(1);
        plan.push_back(t_in_item'({2'd3, 113'h1_FFFF_FFFF}));
        plan_want.push_back(want); plan_has.push_back(1);
        foreach (plan[i]) send_word(plan[i], plan_has[i], plan_want[i]);
        drain();

        write_cfg(CFG_CHUNK_BYTES, 12'd4);
        write_cfg(CFG_SLOTS_IN_USE, 12'd2);
        plan.delete(); plan_want.delete(); plan_has.delete();
        want = '0;
        want.status = ST_TOO_BIG;
        plan.push_back(enq(12'd4, 8'h00, 1'b0, 32'h0));
        plan_want.push_back(want); plan_has.push_back(1);
        plan.push_back(enq(12'd3, 8'hA5, 1'b0, 32'h0));
        plan.push_back(enq(12'd3, 8'h5A, 1'b0, 32'h0));
        plan.push_back(enq(12'd3, 8'h00, 1'b0, 32'h0));
        plan.push_back(enq(12'd3, 8'h11, 1'b1, 32'hFFFF_FFFF));
        plan.push_back(enq(12'd0, 8'hEE, 1'b1, 32'h1234_5678));
        plan.push_back(enq(12'd1, 8'h01, 1'b1, 32'h0));
        plan.push_back(rd(32'h0001_0000, 16'd2, 12'd0));
        plan.push_back(rd(32'h0001_0000, 16'hFFFF, 12'd1));
        plan.push_back(rd(32'h0001_0000, 16'hFFFF, 12'hFFF));
        plan.push_back(rd(32'hFFFF_FFFF, 16'hFFFF, 12'd0));
        plan.push_back(t_in_item'({OP_RELEASE, 113'h0}));
        plan.push_back(enq(12'd2, 8'h77, 1'b1, 32'h0));
        plan.push_back(rd(32'h0003_0000, 16'hFFFF, 12'd0));
        for (int i = 1; i < plan.size(); i++) begin
            plan_want.push_back('0);
            plan_has.push_back(0);
        end
        foreach (plan[i]) send_word(plan[i], plan_has[i], plan_want[i]);
        drain();

        // random phases over several settings
        write_cfg(CFG_CHUNK_BYTES, 12'd255);
        write_cfg(CFG_SLOTS_IN_USE, 12'd16);
        random_phase(60);
        drain();
        write_cfg(CFG_CHUNK_BYTES, 12'd1);
        write_cfg(CFG_SLOTS_IN_USE, 12'd1);
        random_phase(40);
        drain();
        send_idle = 73;
        recv_idle = 13;
        write_cfg(CFG_CHUNK_BYTES, 12'd4095);
        write_cfg(CFG_SLOTS_IN_USE, 12'd31);
        random_phase(20);
        drain();
        write_cfg(CFG_CHUNK_BYTES, 12'd8);
        write_cfg(CFG_SLOTS_IN_USE, 12'd0);
        random_phase(20);
        drain();
        write_cfg(CFG_SLOTS_IN_USE, 12'd5);
        random_phase(150);
        drain();
        send_idle = 0;
        recv_idle = 0;
        write_cfg(CFG_CHUNK_BYTES, 12'd16);
        write_cfg(CFG_SLOTS_IN_USE, 12'd16);
        random_phase(200);
        drain();

        $display("tb: %0d words sent, %0d results checked, %0d published, %0d reads",
                 n_words, n_results, n_pub, n_reads);
        $display("tb: settings from 1x1 up to 4095-byte slots, bad settings included");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule
